>>> rtl/lfrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared types and codes for the link failover retry sequencer: item
// structs, configuration bundle, mode, command and status codes.
// ----------------------------------------------------------------------------
package lfrs_pkg;

  localparam int TimeW   = 32;
  localparam int StatusW = 8;
  localparam int CmdW    = 2;
  localparam int ModeW   = 3;
  localparam int CfgIdxW = 3;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_PRIMARY_PRESENT   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SECONDARY_PRESENT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESTART_DELAY     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RECHECK_DELAY     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ATTEMPT_WINDOW    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_POLL_INTERVAL     = 3'd5;

  // Configuration reset values
  localparam logic [TimeW-1:0] RESTART_DELAY_RST  = 32'd20000;
  localparam logic [TimeW-1:0] RECHECK_DELAY_RST  = 32'd30000;
  localparam logic [TimeW-1:0] ATTEMPT_WINDOW_RST = 32'd20000;
  localparam logic [TimeW-1:0] POLL_INTERVAL_RST  = 32'd2000;

  // Connection modes
  localparam logic [ModeW-1:0] MODE_IDLE     = 3'd0;
  localparam logic [ModeW-1:0] MODE_TRY_PRI  = 3'd1;
  localparam logic [ModeW-1:0] MODE_TRY_SEC  = 3'd2;
  localparam logic [ModeW-1:0] MODE_CONN_PRI = 3'd3;
  localparam logic [ModeW-1:0] MODE_CONN_SEC = 3'd4;

  // Connect commands
  localparam logic [CmdW-1:0] CMD_NONE    = 2'd0;
  localparam logic [CmdW-1:0] CMD_PRIMARY = 2'd1;
  localparam logic [CmdW-1:0] CMD_SECOND  = 2'd2;

  // Radio status codes
  localparam logic [StatusW-1:0] STATUS_CONNECTED    = 8'd3;
  localparam logic [StatusW-1:0] STATUS_DISCONNECTED = 8'd6;

  typedef struct packed {
    logic [TimeW-1:0]   now_time;
    logic [StatusW-1:0] link_status;
  } in_item_t;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [ModeW-1:0] conn_state;
  } out_item_t;

  typedef struct packed {
    logic             primary_present;
    logic             secondary_present;
    logic [TimeW-1:0] restart_delay;
    logic [TimeW-1:0] recheck_delay;
    logic [TimeW-1:0] attempt_window;
    logic [TimeW-1:0] poll_interval;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/lfrs_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfrs_cfg
// Configuration register file: decodes the write port into the six
// sequencer settings and presents them as one bundle.
// ----------------------------------------------------------------------------
module lfrs_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [lfrs_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [lfrs_pkg::TimeW-1:0] cfg_data,
  output lfrs_pkg::cfg_t                  cfg
);
  import lfrs_pkg::*;

  // Load the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.primary_present   <= 1'b0;
      cfg.secondary_present <= 1'b0;
      cfg.restart_delay     <= RESTART_DELAY_RST;
      cfg.recheck_delay     <= RECHECK_DELAY_RST;
      cfg.attempt_window    <= ATTEMPT_WINDOW_RST;
      cfg.poll_interval     <= POLL_INTERVAL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PRIMARY_PRESENT:   cfg.primary_present   <= cfg_data[0];
        REG_SECONDARY_PRESENT: cfg.secondary_present <= cfg_data[0];
        REG_RESTART_DELAY:     cfg.restart_delay     <= cfg_data;
        REG_RECHECK_DELAY:     cfg.recheck_delay     <= cfg_data;
        REG_ATTEMPT_WINDOW:    cfg.attempt_window    <= cfg_data;
        REG_POLL_INTERVAL:     cfg.poll_interval     <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/lfrs_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfrs_core
// Sequencer state (mode, deadline, attempt start) and the combinational
// step logic that turns one tick into a command and the new mode.
// ----------------------------------------------------------------------------
module lfrs_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lfrs_pkg::cfg_t      cfg,
  input  wire logic                step,
  input  wire lfrs_pkg::in_item_t  item,
  output lfrs_pkg::out_item_t      result
);
  import lfrs_pkg::*;

  logic [ModeW-1:0] mode;
  logic [TimeW-1:0] deadline;
  logic [TimeW-1:0] attempt_start;

  logic [ModeW-1:0] mode_next;
  logic [TimeW-1:0] deadline_next;
  logic             deadline_load;
  logic             start_load;
  logic [TimeW-1:0] delay;
  logic [CmdW-1:0]  cmd;
  logic             due;
  logic             in_window;
  logic             is_conn;
  logic             is_disc;
  logic             do_start;
  logic             start_sec;
  logic             present;
  logic [TimeW-1:0] elapsed;

  assign due       = (item.now_time >= deadline);
  assign elapsed   = item.now_time - attempt_start;
  assign in_window = (elapsed < cfg.attempt_window);
  assign is_conn   = (item.link_status == STATUS_CONNECTED);
  assign is_disc   = (item.link_status == STATUS_DISCONNECTED);

  // Decide the next mode, the delay to arm and the command
  always_comb begin
    mode_next     = mode;
    deadline_load = 1'b0;
    start_load    = 1'b0;
    delay         = cfg.poll_interval;
    cmd           = CMD_NONE;
    do_start      = 1'b0;
    start_sec     = 1'b0;
    present       = 1'b0;
    if (due) begin
      case (mode)
        MODE_IDLE: begin
          do_start = 1'b1;
        end
        MODE_TRY_PRI, MODE_TRY_SEC: begin
          deadline_load = 1'b1;
          if (is_conn) begin
            mode_next = (mode == MODE_TRY_SEC) ? MODE_CONN_SEC : MODE_CONN_PRI;
            delay     = cfg.recheck_delay;
          end else if (is_disc && in_window) begin
            delay = cfg.poll_interval;
          end else if (mode == MODE_TRY_PRI) begin
            do_start  = 1'b1;
            start_sec = 1'b1;
          end else begin
            mode_next = MODE_IDLE;
            delay     = cfg.restart_delay;
          end
        end
        MODE_CONN_PRI, MODE_CONN_SEC: begin
          if (!is_conn) begin
            // Link lost: drop to idle, keep the deadline
            mode_next = MODE_IDLE;
          end else if (mode == MODE_CONN_SEC) begin
            do_start = 1'b1;
          end else begin
            deadline_load = 1'b1;
            delay         = cfg.recheck_delay;
          end
        end
        default: ;
      endcase

      // Start an attempt, or fall to the restart wait with no network
      present = start_sec ? cfg.secondary_present : cfg.primary_present;
      if (do_start) begin
        deadline_load = 1'b1;
        if (present) begin
          mode_next  = start_sec ? MODE_TRY_SEC : MODE_TRY_PRI;
          start_load = 1'b1;
          delay      = cfg.poll_interval;
          cmd        = start_sec ? CMD_SECOND : CMD_PRIMARY;
        end else begin
          mode_next = MODE_IDLE;
          delay     = cfg.restart_delay;
        end
      end
    end
  end

  assign deadline_next     = item.now_time + delay;
  assign result.command    = cmd;
  assign result.conn_state = mode_next;

  // Advance the state on each processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      deadline      <= '0;
      attempt_start <= '0;
    end else if (step) begin
      mode <= mode_next;
      if (deadline_load) begin
        deadline <= deadline_next;
      end
      if (start_load) begin
        attempt_start <= item.now_time;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/link_failover_retry_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// link_failover_retry_sequencer
// Primary/secondary link failover sequencer: one tick in, one command and
// connection state out.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-----------------------------
//   in      | input     | in_valid / in_ready  | in_item (now_time, status)
//   out     | output    | out_valid / out_ready| out_item (command, state)
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// An item is captured in the input register, stepped through the sequencer
// logic and lands in the result register; one item per cycle is sustained
// while out_ready is high.
// Reset is synchronous and returns the mode to idle with a zero deadline.
// When the result register is held by out_ready low, the input register
// holds too and in_ready drops once it is full.
// ----------------------------------------------------------------------------
module link_failover_retry_sequencer (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire lfrs_pkg::in_item_t           in_item,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output lfrs_pkg::out_item_t               out_item,
  input  wire logic                         cfg_write,
  input  wire logic [lfrs_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [lfrs_pkg::TimeW-1:0]   cfg_data
);
  import lfrs_pkg::*;

  cfg_t      cfg;
  in_item_t  hold_item;
  logic      hold_valid;
  out_item_t step_result;
  logic      out_free;
  logic      advance;

  lfrs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lfrs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .step   (advance),
    .item   (hold_item),
    .result (step_result)
  );

  assign out_free = !out_valid || out_ready;
  assign advance  = hold_valid && out_free;
  assign in_ready = !hold_valid || out_free;

  // Input register: capture a new item when the slot frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_item <= in_item;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= step_result;
    end
  end

endmodule
`default_nettype wire

>>> dv/link_failover_retry_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_failover_retry_sequencer_tb
// Self-checking bench for the link failover sequencer. A directed table walks
// the primary, secondary, restart and connected paths, plus the time and
// register extremes. Random phases then follow, each with its own register
// setting. Every accepted tick is stepped through a local model of the
// sequencer, and each result item is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module link_failover_retry_sequencer_tb;
  import lfrs_pkg::*;

  localparam int DRAIN_CYCLES   = 4;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASES         = 10;
  localparam int PHASE_TICKS    = 110;
  localparam int PRINT_CAP      = 40;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    in_item_t             tick;
    logic [CfgIdxW-1:0]   index;
    logic [TimeW-1:0]     data;
    logic                 typed;
    out_item_t            result;
  } plan_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_item;
  logic               cfg_write;
  logic [CfgIdxW-1:0] cfg_index;
  logic [TimeW-1:0]   cfg_data;

  // Local copy of the sequencer state and registers
  cfg_t               seq_cfg;
  logic [ModeW-1:0]   seq_mode;
  logic [TimeW-1:0]   seq_deadline;
  logic [TimeW-1:0]   seq_start;

  out_item_t          pending_results[$];
  plan_row_t          plan[$];
  int                 mismatch_count;
  int                 idle_cycles;
  bit                 quiet;
  logic [TimeW-1:0]   clock_ms;

  link_failover_retry_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sequencer model
  // ---------------------------------------------------------------------------
  function automatic logic [CmdW-1:0] enter_restart_wait(logic [TimeW-1:0] now);
    seq_mode     = MODE_IDLE;
    seq_deadline = now + seq_cfg.restart_delay;
    return CMD_NONE;
  endfunction

  function automatic logic [CmdW-1:0] begin_attempt(bit use_sec, logic [TimeW-1:0] now);
    logic present;
    present = use_sec ? seq_cfg.secondary_present : seq_cfg.primary_present;
    if (!present) return enter_restart_wait(now);
    seq_start    = now;
    seq_mode     = use_sec ? MODE_TRY_SEC : MODE_TRY_PRI;
    seq_deadline = now + seq_cfg.poll_interval;
    return use_sec ? CMD_SECOND : CMD_PRIMARY;
  endfunction

  function automatic logic [CmdW-1:0] poll_attempt(bit use_sec, logic [TimeW-1:0] now,
                                                   logic [StatusW-1:0] status);
    logic [TimeW-1:0] elapsed;
    elapsed      = now - seq_start;
    seq_deadline = now + seq_cfg.poll_interval;
    if (status == STATUS_CONNECTED) begin
      seq_mode     = use_sec ? MODE_CONN_SEC : MODE_CONN_PRI;
      seq_deadline = now + seq_cfg.recheck_delay;
      return CMD_NONE;
    end
    if (status == STATUS_DISCONNECTED && elapsed < seq_cfg.attempt_window) return CMD_NONE;
    if (!use_sec) return begin_attempt(1'b1, now);
    return enter_restart_wait(now);
  endfunction

  function automatic logic [CmdW-1:0] poll_link(bit use_sec, logic [TimeW-1:0] now,
                                                logic [StatusW-1:0] status);
    if (status == STATUS_CONNECTED) begin
      if (use_sec) return begin_attempt(1'b0, now);
      seq_deadline = now + seq_cfg.recheck_delay;
      return CMD_NONE;
    end
    // Link lost: back to idle, deadline kept
    seq_mode = MODE_IDLE;
    return CMD_NONE;
  endfunction

  function automatic out_item_t sequencer_step(in_item_t it);
    out_item_t res;
    logic [CmdW-1:0] cmd;
    cmd = CMD_NONE;
    if (it.now_time >= seq_deadline) begin
      case (seq_mode)
        MODE_IDLE:     cmd = begin_attempt(1'b0, it.now_time);
        MODE_TRY_PRI:  cmd = poll_attempt(1'b0, it.now_time, it.link_status);
        MODE_TRY_SEC:  cmd = poll_attempt(1'b1, it.now_time, it.link_status);
        MODE_CONN_PRI: cmd = poll_link(1'b0, it.now_time, it.link_status);
        MODE_CONN_SEC: cmd = poll_link(1'b1, it.now_time, it.link_status);
        default: ;
      endcase
    end
    res.command    = cmd;
    res.conn_state = seq_mode;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    if (mismatch_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [TimeW-1:0] pick_delay();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 80) return $urandom_range(1, 5000);
    if (r < 92) return $urandom_range(5001, 100000);
    return $urandom;
  endfunction

  function automatic void add_tick(logic [TimeW-1:0] now, logic [StatusW-1:0] status);
    plan_row_t row;
    row             = '0;
    row.kind        = ROW_TICK;
    row.tick        = '{now_time: now, link_status: status};
    plan.push_back(row);
  endfunction

  function automatic void add_check(logic [TimeW-1:0] now, logic [StatusW-1:0] status,
                                    logic [CmdW-1:0] cmd, logic [ModeW-1:0] state);
    plan_row_t row;
    row             = '0;
    row.kind        = ROW_TICK;
    row.tick        = '{now_time: now, link_status: status};
    row.typed       = 1'b1;
    row.result      = '{command: cmd, conn_state: state};
    plan.push_back(row);
  endfunction

  function automatic void add_write(logic [CfgIdxW-1:0] index, logic [TimeW-1:0] data);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = index;
    row.data  = data;
    plan.push_back(row);
  endfunction

  // Drop valid; must be called right after an item is taken
  task automatic release_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Present one tick, hold it until taken, then predict its result
  task automatic send_tick(in_item_t it, bit typed, out_item_t typed_result);
    int gap;
    out_item_t predicted;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = sequencer_step(it);
    pending_results.push_back(typed ? typed_result : predicted);
  endtask

  // Wait out every outstanding result, then the pipeline
  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register with the block idle
  task automatic write_reg(logic [CfgIdxW-1:0] index, logic [TimeW-1:0] data);
    release_input();
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    case (index)
      REG_PRIMARY_PRESENT:   seq_cfg.primary_present   = data[0];
      REG_SECONDARY_PRESENT: seq_cfg.secondary_present = data[0];
      REG_RESTART_DELAY:     seq_cfg.restart_delay     = data;
      REG_RECHECK_DELAY:     seq_cfg.recheck_delay     = data;
      REG_ATTEMPT_WINDOW:    seq_cfg.attempt_window    = data;
      REG_POLL_INTERVAL:     seq_cfg.poll_interval     = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Register setting for one random phase: minimum, maximum, then random
  task automatic configure_phase(int phase);
    logic [TimeW-1:0] upper;
    upper = $urandom;
    write_reg(REG_PRIMARY_PRESENT,
              {upper[31:1], (phase == 1) ? 1'b1 : ($urandom_range(0, 9) != 0)});
    write_reg(REG_SECONDARY_PRESENT,
              {upper[31:1], (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0)});
    if (phase == 0) begin
      write_reg(REG_RESTART_DELAY,  '0);
      write_reg(REG_RECHECK_DELAY,  '0);
      write_reg(REG_ATTEMPT_WINDOW, '0);
      write_reg(REG_POLL_INTERVAL,  '0);
    end else if (phase == 1) begin
      write_reg(REG_RESTART_DELAY,  '1);
      write_reg(REG_RECHECK_DELAY,  '1);
      write_reg(REG_ATTEMPT_WINDOW, '1);
      write_reg(REG_POLL_INTERVAL,  '1);
    end else begin
      write_reg(REG_RESTART_DELAY,  pick_delay());
      write_reg(REG_RECHECK_DELAY,  pick_delay());
      write_reg(REG_ATTEMPT_WINDOW, pick_delay());
      write_reg(REG_POLL_INTERVAL,  pick_delay());
    end
  endtask

  // Mostly advance time toward the next deadline; sometimes jump anywhere
  function automatic in_item_t next_random_tick();
    in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      clock_ms = clock_ms + $urandom_range(0, 3000);
    else if (r < 70) clock_ms = seq_deadline + $urandom_range(0, 2);
    else if (r < 78) clock_ms = seq_deadline - 1;
    else if (r < 93) clock_ms = clock_ms + $urandom_range(3000, 40000);
    else             clock_ms = $urandom;
    it.now_time = clock_ms;
    r = $urandom_range(0, 99);
    if (r < 45)      it.link_status = STATUS_CONNECTED;
    else if (r < 85) it.link_status = STATUS_DISCONNECTED;
    else             it.link_status = StatusW'($urandom_range(0, 255));
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random backpressure
  // ---------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30) stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Check results and watch for a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_item;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result cmd=%0d state=%0d",
                                    out_item.command, out_item.conn_state));
        end else begin
          exp_item = pending_results.pop_front();
          if (out_item.command !== exp_item.command)
            report_mismatch($sformatf("command got %0d want %0d",
                                      out_item.command, exp_item.command));
          if (out_item.conn_state !== exp_item.conn_state)
            report_mismatch($sformatf("conn_state got %0d want %0d",
                                      out_item.conn_state, exp_item.conn_state));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    plan_row_t row;
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_item        = '0;
    cfg_write      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    quiet          = 1'b0;
    mismatch_count = 0;
    clock_ms       = '0;

    seq_cfg                   = '0;
    seq_cfg.restart_delay     = RESTART_DELAY_RST;
    seq_cfg.recheck_delay     = RECHECK_DELAY_RST;
    seq_cfg.attempt_window    = ATTEMPT_WINDOW_RST;
    seq_cfg.poll_interval     = POLL_INTERVAL_RST;
    seq_mode                  = MODE_IDLE;
    seq_deadline              = '0;
    seq_start                 = '0;

    // No network after reset: restart wait, then nothing before the deadline
    add_check(32'd0, 8'd0, CMD_NONE, MODE_IDLE);
    add_check(32'd100, STATUS_CONNECTED, CMD_NONE, MODE_IDLE);
    add_write(REG_PRIMARY_PRESENT, 32'd1);
    add_write(REG_SECONDARY_PRESENT, 32'd1);
    add_check(32'd20000, 8'd0, CMD_PRIMARY, MODE_TRY_PRI);
    // Disconnected inside the window, then window expiry to secondary
    add_tick(32'd22000, STATUS_DISCONNECTED);
    add_tick(32'd40000, STATUS_DISCONNECTED);
    add_tick(32'd42000, STATUS_CONNECTED);
    // Connected on secondary retries primary
    add_tick(32'd72000, STATUS_CONNECTED);
    add_tick(32'd74000, STATUS_CONNECTED);
    add_tick(32'd104000, STATUS_CONNECTED);
    // Link lost keeps the deadline
    add_tick(32'd134000, 8'hFF);
    add_tick(32'd134000, 8'd0);
    add_tick(32'd136000, 8'd0);
    add_tick(32'd138000, 8'd7);
    // Secondary absent: primary error goes straight to restart wait
    add_write(REG_SECONDARY_PRESENT, 32'hFFFF_FFFE);
    add_tick(32'd158000, 8'd0);
    add_tick(32'd160000, 8'h80);
    // Register and time extremes with deadline wrap
    add_write(REG_POLL_INTERVAL, 32'd0);
    add_write(REG_ATTEMPT_WINDOW, 32'd0);
    add_write(REG_RESTART_DELAY, 32'hFFFF_FFFF);
    add_write(REG_RECHECK_DELAY, 32'hFFFF_FFFF);
    add_check(32'hFFFF_FFFF, STATUS_DISCONNECTED, CMD_PRIMARY, MODE_TRY_PRI);
    add_tick(32'hFFFF_FFFF, STATUS_DISCONNECTED);
    add_tick(32'd0, STATUS_CONNECTED);
    add_tick(32'hFFFF_FFFE, STATUS_CONNECTED);
    add_tick(32'hFFFF_FFFE, STATUS_CONNECTED);
    add_tick(32'hFFFF_FFFD, STATUS_CONNECTED);
    add_tick(32'hFFFF_FFFD, STATUS_DISCONNECTED);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) write_reg(row.index, row.data);
      else send_tick(row.tick, row.typed, row.result);
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      configure_phase(phase);
      quiet    = (phase % 4 == 3);
      clock_ms = seq_deadline;
      for (int n = 0; n < PHASE_TICKS; n++) send_tick(next_random_tick(), 1'b0, '0);
      quiet = 1'b0;
    end

    release_input();
    drain();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
